@@ rtl/raycast_wall_column_setup_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the wall column setup unit
// Shared concurrent check forms: implication in the same cycle and next cycle.
// ----------------------------------------------------------------------------
`ifndef RAYCAST_WALL_COLUMN_SETUP_UNIT_DEFINES_SVH
`define RAYCAST_WALL_COLUMN_SETUP_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RWCS_ASSERT_IMP(lbl, clk, rst_n, a, c) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("rwcs check failed");
`define RWCS_ASSERT_NXT(lbl, clk, rst_n, a, c) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("rwcs check failed");
`else
`define RWCS_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define RWCS_ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif
`endif

@@ rtl/rwcs_pkg.sv @@
// ----------------------------------------------------------------------------
// rwcs_pkg
// Types, constants and codes shared by the wall column setup unit.
// ----------------------------------------------------------------------------
package rwcs_pkg;

	// screen and texture geometry
	localparam int SCREEN_ROWS = 512;
	localparam int TEX_SIZE    = 64;
	localparam int HALF_ROWS   = SCREEN_ROWS / 2;

	// field widths
	localparam int POS_W    = 24;
	localparam int DIR_W    = 18;
	localparam int CELL_W   = 8;
	localparam int STEP_W   = 2;
	localparam int DIST_W   = 24;
	localparam int HEIGHT_W = 12;
	localparam int ROW_W    = 9;
	localparam int TEXC_W   = 6;
	localparam int FRAC_W   = 16;
	localparam int NUM_W    = 26;
	localparam int AN_W     = 25;
	localparam int SPAN_W   = 14;
	localparam int TEXK_W   = 11;

	localparam logic [DIST_W-1:0]   DIST_MAX   = '1;
	localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = '1;

	// divider schedule: quotient bits retired per cycle
	localparam int RADIX_BITS = 3;
	localparam int DIV1_STEPS = DIST_W / RADIX_BITS;
	localparam int DIV2_STEPS = HEIGHT_W / RADIX_BITS;
	localparam int CNT_W      = $clog2(DIV1_STEPS);

	// height division: first partial remainder, also the saturation limit
	localparam logic [DIST_W:0] HT_REM0 = 25'((SCREEN_ROWS * 65536) >> HEIGHT_W);

	// job queue
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = 1;
	localparam int FIFO_CW    = 2;

	// configuration
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_PLAYER_X = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PLAYER_Y = 1'b1;

	typedef enum logic [1:0] {
		FACE_WEST  = 2'd0,
		FACE_EAST  = 2'd1,
		FACE_NORTH = 2'd2,
		FACE_SOUTH = 2'd3
	} facing_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV1,
		ST_HSET,
		ST_DIV2,
		ST_DONE
	} back_state_t;

	// classified ray, as queued between front and back
	typedef struct packed {
		logic [AN_W-1:0]         an;
		logic [DIR_W-1:0]        ad;
		logic                    neg;
		logic signed [DIR_W-1:0] other_dir;
		logic [FRAC_W-1:0]       other_pos;
		logic                    mirror;
		facing_t                 facing;
	} ray_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

endpackage

@@ rtl/rwcs_if.sv @@
// ----------------------------------------------------------------------------
// rwcs channel interfaces
// Ray hit channel in, wall column channel out, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rwcs_ray_if;
	logic                            valid;
	logic                            ready;
	logic                            hit_side;
	logic signed [rwcs_pkg::DIR_W-1:0]  dir_x;
	logic signed [rwcs_pkg::DIR_W-1:0]  dir_y;
	logic [rwcs_pkg::CELL_W-1:0]     cell_x;
	logic [rwcs_pkg::CELL_W-1:0]     cell_y;
	logic signed [rwcs_pkg::STEP_W-1:0] step_sign_x;
	logic signed [rwcs_pkg::STEP_W-1:0] step_sign_y;

	modport source (output valid, hit_side, dir_x, dir_y, cell_x, cell_y,
		step_sign_x, step_sign_y, input ready);
	modport sink (input valid, hit_side, dir_x, dir_y, cell_x, cell_y,
		step_sign_x, step_sign_y, output ready);
endinterface

interface rwcs_col_if;
	logic                          valid;
	logic                          ready;
	logic [rwcs_pkg::DIST_W-1:0]   perp_distance;
	logic [rwcs_pkg::HEIGHT_W-1:0] column_height;
	logic [rwcs_pkg::ROW_W-1:0]    span_start;
	logic [rwcs_pkg::ROW_W-1:0]    span_end;
	logic [rwcs_pkg::TEXC_W-1:0]   texture_column;
	logic [1:0]                    facing;

	modport source (output valid, perp_distance, column_height, span_start,
		span_end, texture_column, facing, input ready);
	modport sink (input valid, perp_distance, column_height, span_start,
		span_end, texture_column, facing, output ready);
endinterface

@@ rtl/raycast_wall_column_setup_unit.sv @@
// ----------------------------------------------------------------------------
// raycast_wall_column_setup_unit
// Wall column setup for one raycaster ray: distance, height, span, texture.
// ----------------------------------------------------------------------------
// Usage:
//   ray is the input channel: one word per ray wall hit (side, direction,
//   map cell, step signs). col is the output channel: one word per ray with
//   perpendicular distance, wall height, draw span, texture column, facing.
//   The player position is written through cfg_we/cfg_index/cfg_wdata
//   (index 0 = x, index 1 = y) while no ray is in flight.
// Operation:
//   A ray passes through these steps from acceptance to col.valid: it is
//   taken from the queue, the distance divider runs (3 quotient bits a
//   cycle), a setup state follows, the height divider runs and the output
//   word is loaded. Saturated or zero cases skip one or both dividers.
//   One shared divider sequencer handles one ray at a time and so sets
//   the sustained rate.
//   A two-word queue sits before the divider, so ray words are accepted back
//   to back, until it fills, while the back end is busy or the output word waits.
// Reset clears the player position, the queue and the output valid.
// When col.ready is low the output word holds; the back end stops once it
// has a finished word, and ray.ready drops when the queue fills.
// ----------------------------------------------------------------------------
module raycast_wall_column_setup_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rwcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rwcs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	rwcs_ray_if.sink                        ray,
	rwcs_col_if.source                      col
);

	rwcs_pkg::ray_job_t     push_job, head_job;
	rwcs_pkg::fifo_status_t fifo_st;
	logic                   push, pop;

	rwcs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.ray       (ray),
		.fifo_st   (fifo_st),
		.push      (push),
		.job       (push_job)
	);

	rwcs_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_job),
		.pop    (pop),
		.rdata  (head_job),
		.st     (fifo_st)
	);

	rwcs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.job     (head_job),
		.fifo_st (fifo_st),
		.pop     (pop),
		.col     (col)
	);

endmodule

@@ rtl/rwcs_front.sv @@
// ----------------------------------------------------------------------------
// rwcs_front
// Holds the player position and classifies each ray word into a division job.
// ----------------------------------------------------------------------------
module rwcs_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [rwcs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rwcs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	rwcs_ray_if.sink                           ray,
	input  rwcs_pkg::fifo_status_t             fifo_st,
	output logic                               push,
	output rwcs_pkg::ray_job_t                 job
);

	logic [rwcs_pkg::POS_W-1:0] px_q, py_q;

	// player position registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= '0;
			py_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rwcs_pkg::REG_PLAYER_X: px_q <= cfg_wdata;
				rwcs_pkg::REG_PLAYER_Y: py_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign ray.ready = !fifo_st.full;
	assign push      = ray.valid && !fifo_st.full;

	logic [rwcs_pkg::CELL_W-1:0]        cell_sel;
	logic signed [rwcs_pkg::STEP_W-1:0] step;
	logic [rwcs_pkg::POS_W-1:0]         pos;
	logic signed [rwcs_pkg::DIR_W-1:0]  dmain;
	logic [rwcs_pkg::CELL_W:0]          cell_adj;
	logic signed [rwcs_pkg::NUM_W-1:0]  num;
	logic                               dx_pos;

	// pick the axis, form the signed distance to the wall line
	always_comb begin
		dx_pos = !ray.dir_x[rwcs_pkg::DIR_W-1] && (ray.dir_x != '0);
		if (ray.hit_side) begin
			cell_sel      = ray.cell_y;
			step          = ray.step_sign_y;
			pos           = py_q;
			dmain         = ray.dir_y;
			job.other_dir = ray.dir_x;
			job.other_pos = px_q[rwcs_pkg::FRAC_W-1:0];
			job.mirror    = ray.dir_y[rwcs_pkg::DIR_W-1];
			job.facing    = (!ray.dir_y[rwcs_pkg::DIR_W-1] && ray.dir_y != '0) ?
				rwcs_pkg::FACE_NORTH : rwcs_pkg::FACE_SOUTH;
		end else begin
			cell_sel      = ray.cell_x;
			step          = ray.step_sign_x;
			pos           = px_q;
			dmain         = ray.dir_x;
			job.other_dir = ray.dir_y;
			job.other_pos = py_q[rwcs_pkg::FRAC_W-1:0];
			job.mirror    = dx_pos;
			job.facing    = dx_pos ? rwcs_pkg::FACE_WEST : rwcs_pkg::FACE_EAST;
		end
		// a negative step lands on the far edge of the cell
		cell_adj = {1'b0, cell_sel} + {{rwcs_pkg::CELL_W{1'b0}}, step[rwcs_pkg::STEP_W-1]};
		num      = $signed({1'b0, cell_adj, 16'b0}) - $signed({2'b0, pos});
		job.an   = num[rwcs_pkg::NUM_W-1] ? rwcs_pkg::AN_W'(-num) : num[rwcs_pkg::AN_W-1:0];
		job.ad   = dmain[rwcs_pkg::DIR_W-1] ? rwcs_pkg::DIR_W'(-dmain) : dmain;
		job.neg  = num[rwcs_pkg::NUM_W-1] ^ dmain[rwcs_pkg::DIR_W-1];
	end

endmodule

@@ rtl/rwcs_fifo.sv @@
// ----------------------------------------------------------------------------
// rwcs_fifo
// Short job queue between the classifying front and the divider back end.
// ----------------------------------------------------------------------------
`include "raycast_wall_column_setup_unit_defines.svh"

module rwcs_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  rwcs_pkg::ray_job_t     wdata,
	input  logic                   pop,
	output rwcs_pkg::ray_job_t     rdata,
	output rwcs_pkg::fifo_status_t st
);

	rwcs_pkg::ray_job_t mem_q [rwcs_pkg::FIFO_DEPTH];
	logic [rwcs_pkg::FIFO_AW-1:0] wr_q, rd_q;
	logic [rwcs_pkg::FIFO_CW-1:0] count_q;

	assign st.full  = (count_q == rwcs_pkg::FIFO_CW'(rwcs_pkg::FIFO_DEPTH));
	assign st.empty = (count_q == '0);
	assign rdata    = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == rwcs_pkg::FIFO_AW'(rwcs_pkg::FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == rwcs_pkg::FIFO_AW'(rwcs_pkg::FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	`RWCS_ASSERT_IMP(a_no_overflow, clk, arst_n, push, !st.full)
	`RWCS_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, !st.empty)
	`RWCS_ASSERT_IMP(a_count_range, clk, arst_n, 1'b1,
		count_q <= rwcs_pkg::FIFO_CW'(rwcs_pkg::FIFO_DEPTH))

endmodule

@@ rtl/rwcs_back.sv @@
// ----------------------------------------------------------------------------
// rwcs_back
// Divider sequencer: distance, height, texture hit point and output register.
// ----------------------------------------------------------------------------
`include "raycast_wall_column_setup_unit_defines.svh"

module rwcs_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rwcs_pkg::ray_job_t     job,
	input  rwcs_pkg::fifo_status_t fifo_st,
	output logic                   pop,
	rwcs_col_if.source             col
);

	rwcs_pkg::back_state_t state_q, state_d;

	logic [rwcs_pkg::CNT_W-1:0]     cnt_q;
	logic [rwcs_pkg::DIR_W-1:0]     ad_q;
	logic [rwcs_pkg::DIR_W-1:0]     rem1_q;
	logic [rwcs_pkg::DIST_W-1:0]    dvd_q;
	logic [rwcs_pkg::DIST_W-1:0]    dist_q;
	logic [rwcs_pkg::DIST_W:0]      rem2_q;
	logic [rwcs_pkg::HEIGHT_W-1:0]  ht_q;
	logic signed [rwcs_pkg::DIR_W-1:0] odir_q;
	logic [rwcs_pkg::FRAC_W-1:0]    opos_q;
	logic [rwcs_pkg::FRAC_W-1:0]    prod_q;
	logic                           mirror_q;
	rwcs_pkg::facing_t              facing_q;
	logic                           out_valid_q;

	logic out_load, sat1, zero1, ht_sat;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rwcs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// distance precheck on the queued job
	assign sat1  = (job.ad == '0) || ({1'b0, job.an} >= {job.ad, 8'b0});
	assign zero1 = job.neg || (job.an == '0);
	assign ht_sat = ({1'b0, dist_q} <= rwcs_pkg::HT_REM0);

	// next state and handshake
	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			rwcs_pkg::ST_IDLE: begin
				if (!fifo_st.empty) begin
					pop     = 1'b1;
					state_d = (sat1 || zero1) ? rwcs_pkg::ST_HSET : rwcs_pkg::ST_DIV1;
				end
			end
			rwcs_pkg::ST_DIV1: begin
				if (cnt_q == rwcs_pkg::CNT_W'(rwcs_pkg::DIV1_STEPS - 1)) begin
					state_d = rwcs_pkg::ST_HSET;
				end
			end
			rwcs_pkg::ST_HSET: begin
				state_d = ht_sat ? rwcs_pkg::ST_DONE : rwcs_pkg::ST_DIV2;
			end
			rwcs_pkg::ST_DIV2: begin
				if (cnt_q == rwcs_pkg::CNT_W'(rwcs_pkg::DIV2_STEPS - 1)) begin
					state_d = rwcs_pkg::ST_DONE;
				end
			end
			rwcs_pkg::ST_DONE: begin
				if (!out_valid_q || col.ready) begin
					out_load = 1'b1;
					state_d  = rwcs_pkg::ST_IDLE;
				end
			end
			default: state_d = rwcs_pkg::ST_IDLE;
		endcase
	end

	// distance divider, three quotient bits a cycle
	logic [rwcs_pkg::DIR_W-1:0]  r1;
	logic [rwcs_pkg::DIST_W-1:0] dv1, q1;
	always_comb begin
		r1  = rem1_q;
		dv1 = dvd_q;
		q1  = dist_q;
		for (int i = 0; i < rwcs_pkg::RADIX_BITS; i++) begin
			r1  = {r1[rwcs_pkg::DIR_W-2:0], dv1[rwcs_pkg::DIST_W-1]};
			dv1 = {dv1[rwcs_pkg::DIST_W-2:0], 1'b0};
			if (r1 >= ad_q) begin
				r1 = r1 - ad_q;
				q1 = {q1[rwcs_pkg::DIST_W-2:0], 1'b1};
			end else begin
				q1 = {q1[rwcs_pkg::DIST_W-2:0], 1'b0};
			end
		end
	end

	// height divider, three quotient bits a cycle
	logic [rwcs_pkg::DIST_W:0]     r2;
	logic [rwcs_pkg::HEIGHT_W-1:0] q2;
	always_comb begin
		r2 = rem2_q;
		q2 = ht_q;
		for (int i = 0; i < rwcs_pkg::RADIX_BITS; i++) begin
			r2 = {r2[rwcs_pkg::DIST_W-1:0], 1'b0};
			if (r2 >= {1'b0, dist_q}) begin
				r2 = r2 - {1'b0, dist_q};
				q2 = {q2[rwcs_pkg::HEIGHT_W-2:0], 1'b1};
			end else begin
				q2 = {q2[rwcs_pkg::HEIGHT_W-2:0], 1'b0};
			end
		end
	end

	// hit point offset along the wall
	logic signed [rwcs_pkg::DIST_W+rwcs_pkg::DIR_W:0] prod_full;
	assign prod_full = $signed({1'b0, dist_q}) * odir_q;

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			rwcs_pkg::ST_IDLE: begin
				cnt_q    <= '0;
				ad_q     <= job.ad;
				rem1_q   <= {1'b0, job.an[rwcs_pkg::AN_W-1:8]};
				dvd_q    <= {job.an[7:0], 16'b0};
				odir_q   <= job.other_dir;
				opos_q   <= job.other_pos;
				mirror_q <= job.mirror;
				facing_q <= job.facing;
				// zero direction saturates; a wrong-side hit is zero even when huge
				dist_q   <= ((job.ad == '0) || (sat1 && !zero1)) ? rwcs_pkg::DIST_MAX : '0;
			end
			rwcs_pkg::ST_DIV1: begin
				cnt_q  <= cnt_q + 1'b1;
				rem1_q <= r1;
				dvd_q  <= dv1;
				dist_q <= q1;
			end
			rwcs_pkg::ST_HSET: begin
				cnt_q  <= '0;
				rem2_q <= rwcs_pkg::HT_REM0;
				ht_q   <= ht_sat ? rwcs_pkg::HEIGHT_MAX : '0;
				prod_q <= prod_full[31:16];
			end
			rwcs_pkg::ST_DIV2: begin
				cnt_q  <= cnt_q + 1'b1;
				rem2_q <= r2;
				ht_q   <= q2;
			end
			default: ;
		endcase
	end

	// span and texture column from the finished quotients
	logic [rwcs_pkg::HEIGHT_W-2:0]          half;
	logic signed [rwcs_pkg::SPAN_W-1:0]     st_s;
	logic [rwcs_pkg::SPAN_W-1:0]            en_s;
	logic [rwcs_pkg::FRAC_W-1:0]            frac;
	logic [rwcs_pkg::FRAC_W+rwcs_pkg::TEXK_W-1:0] tprod;
	logic [rwcs_pkg::TEXC_W-1:0]            tex_raw, tex;
	logic [rwcs_pkg::ROW_W-1:0]             start_v, end_v;
	always_comb begin
		half = ht_q[rwcs_pkg::HEIGHT_W-1:1];
		st_s = rwcs_pkg::SPAN_W'(rwcs_pkg::HALF_ROWS) - $signed({3'b0, half});
		en_s = {3'b0, half} + rwcs_pkg::SPAN_W'(rwcs_pkg::HALF_ROWS);
		start_v = st_s[rwcs_pkg::SPAN_W-1] ? '0 : st_s[rwcs_pkg::ROW_W-1:0];
		end_v   = (en_s >= rwcs_pkg::SPAN_W'(rwcs_pkg::SCREEN_ROWS)) ?
			rwcs_pkg::ROW_W'(rwcs_pkg::SCREEN_ROWS - 1) : en_s[rwcs_pkg::ROW_W-1:0];
		frac    = opos_q + prod_q;
		tprod   = {{rwcs_pkg::TEXK_W{1'b0}}, frac} *
			(rwcs_pkg::FRAC_W + rwcs_pkg::TEXK_W)'(rwcs_pkg::TEX_SIZE);
		tex_raw = tprod[rwcs_pkg::FRAC_W+rwcs_pkg::TEXC_W-1:rwcs_pkg::FRAC_W];
		tex     = mirror_q ? rwcs_pkg::TEXC_W'(rwcs_pkg::TEX_SIZE - 1) - tex_raw : tex_raw;
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (col.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			col.perp_distance  <= dist_q;
			col.column_height  <= ht_q;
			col.span_start     <= start_v;
			col.span_end       <= end_v;
			col.texture_column <= tex;
			col.facing         <= facing_q;
		end
	end

	assign col.valid = out_valid_q;

	`RWCS_ASSERT_IMP(a_pop_idle, clk, arst_n, pop, state_q == rwcs_pkg::ST_IDLE)
	`RWCS_ASSERT_IMP(a_div2_range, clk, arst_n, state_q == rwcs_pkg::ST_DIV2,
		({1'b0, dist_q} > rwcs_pkg::HT_REM0) && (cnt_q < rwcs_pkg::CNT_W'(rwcs_pkg::DIV2_STEPS)))
	`RWCS_ASSERT_NXT(a_zero_dist_sat, clk, arst_n, out_load && (dist_q == '0),
		col.valid && (col.column_height == rwcs_pkg::HEIGHT_MAX))

endmodule
